[sv/dlts_pkg.sv]
// Package: types, codes and sizes for the delta list task scheduler.
`default_nettype none
package dlts_pkg;

  localparam int unsigned MaxTasksDef = 8;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHR,
    CELL_SHR_ADJ,
    CELL_SHL,
    CELL_TICK
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
  } in_t;

  typedef struct packed {
    logic       ran;
    logic [7:0] ran_id;
    logic [3:0] entries;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] delta;
    logic [31:0] period;
    logic [7:0]  runs;
  } entry_t;

endpackage
`default_nettype wire

[sv/dlts_cell.sv]
// One list entry: holds a task and trades it with its neighbors.
`default_nettype none
module dlts_cell (
  input  wire                  clk_i,
  input  dlts_pkg::cell_op_e   op_i,
  input  dlts_pkg::entry_t     ins_i,
  input  dlts_pkg::entry_t     left_i,
  input  dlts_pkg::entry_t     right_i,
  output dlts_pkg::entry_t     entry_o
);

  dlts_pkg::entry_t entry_q, entry_d;

  // pick the next entry content
  always_comb begin
    entry_d = entry_q;
    case (op_i)
      dlts_pkg::CELL_LOAD:    entry_d = ins_i;
      dlts_pkg::CELL_SHR:     entry_d = left_i;
      dlts_pkg::CELL_SHR_ADJ: begin
        entry_d       = left_i;
        entry_d.delta = left_i.delta - ins_i.delta;
      end
      dlts_pkg::CELL_SHL:     entry_d = right_i;
      dlts_pkg::CELL_TICK: begin
        if (entry_q.delta == 32'd0) begin
          if (entry_q.runs != 8'hFF) entry_d.runs = entry_q.runs + 8'd1;
          if (entry_q.period != 32'd0) entry_d.delta = entry_q.period;
        end else begin
          entry_d.delta = entry_q.delta - 32'd1;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

[sv/delta_list_task_scheduler.sv]
// Top level: delta list timer queue built from a chain of entry cells.
// Usage:
//   Input words (kind, task_id, first_delay, repeat_period) arrive on a
//   valid/ready channel; each yields one output word (ran, ran_id, entries,
//   status) on a second valid/ready channel.
//   Tick and empty/idle words pass through the finish state to the result.
//   Add walks the list one cell per cycle, then loads the task and shifts
//   the tail together; an add to a full list only sets the full status.
//   Dispatch of a periodic head shifts the list up in its accept cycle and
//   reinserts the task by the same walk; a one-shot dispatch only shifts.
//   A single insert pointer walks the cells; one word is in work at a
//   time, and the next is accepted once the block is idle, even while the
//   last result still waits at the output.
//   Reset empties the list and clears the sticky status; entry contents
//   need no clearing. A stalled receiver holds the result register and the
//   block waits in its finish state with the next result.
`default_nettype none
module delta_list_task_scheduler #(
  parameter int unsigned MAX_TASKS = dlts_pkg::MaxTasksDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  dlts_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output dlts_pkg::out_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned PW = $clog2(MAX_TASKS);

  dlts_pkg::state_e     state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [1:0]           err_q, err_d;
  logic                 ran_q, ran_d;
  logic [7:0]           ran_id_q, ran_id_d;
  dlts_pkg::entry_t     tok_q, tok_d;
  logic                 out_valid_q, out_valid_d;
  dlts_pkg::out_t       out_q, out_d;

  dlts_pkg::cell_op_e   ops [MAX_TASKS];
  dlts_pkg::entry_t     cells [MAX_TASKS];
  dlts_pkg::entry_t     ins;

  logic                 in_acc;
  dlts_pkg::entry_t     head;
  dlts_pkg::entry_t     at_pos;
  logic                 at_end;
  logic                 fits;
  // what the control wants done to the chain this cycle
  logic                 do_tick, do_shl, do_place;

  assign in_acc = in_valid_i && in_ready_o;
  assign head   = cells[0];
  assign at_pos = cells[pos_q];
  assign at_end = {{(CW-PW){1'b0}}, pos_q} == count_q;
  assign fits   = tok_q.delta <= at_pos.delta;
  assign ins    = tok_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dlts_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = dlts_pkg::ST_FINISH;
          if (in_data_i.kind == dlts_pkg::KIND_ADD &&
              count_q != CW'(MAX_TASKS)) begin
            state_d = dlts_pkg::ST_WALK;
          end
          if (in_data_i.kind == dlts_pkg::KIND_DISPATCH && count_q != '0 &&
              head.runs != 8'd0 && head.period != 32'd0) begin
            state_d = dlts_pkg::ST_WALK;
          end
        end
      end
      dlts_pkg::ST_WALK: begin
        if (at_end || fits) state_d = dlts_pkg::ST_FINISH;
      end
      dlts_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = dlts_pkg::ST_IDLE;
      end
      default: state_d = dlts_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    err_d       = err_q;
    ran_d       = ran_q;
    ran_id_d    = ran_id_q;
    tok_d       = tok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    do_tick     = 1'b0;
    do_shl      = 1'b0;
    do_place    = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      dlts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          ran_d    = 1'b0;
          ran_id_d = 8'd0;
          pos_d    = '0;
          case (in_data_i.kind)
            dlts_pkg::KIND_ADD: begin
              if (count_q == CW'(MAX_TASKS)) begin
                err_d = dlts_pkg::ERR_FULL;
              end else begin
                tok_d.id     = in_data_i.task_id;
                tok_d.delta  = in_data_i.first_delay;
                tok_d.period = in_data_i.repeat_period;
                tok_d.runs   = 8'd0;
              end
            end
            dlts_pkg::KIND_TICK: begin
              if (count_q == '0) err_d = dlts_pkg::ERR_EMPTY;
              else do_tick = 1'b1;
            end
            dlts_pkg::KIND_DISPATCH: begin
              if (count_q != '0 && head.runs != 8'd0) begin
                ran_d    = 1'b1;
                ran_id_d = head.id;
                do_shl   = 1'b1;
                count_d  = count_q - CW'(1);
                tok_d    = head;
                tok_d.runs = head.runs - 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
      dlts_pkg::ST_WALK: begin
        if (at_end || fits) begin
          do_place = 1'b1;
          count_d  = count_q + CW'(1);
        end else begin
          tok_d.delta = tok_q.delta - at_pos.delta;
          pos_d       = pos_q + PW'(1);
        end
      end
      dlts_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.ran      = ran_q;
          out_d.ran_id   = ran_id_q;
          out_d.entries  = 4'(count_q);
          out_d.status   = err_q;
        end
      end
      default: ;
    endcase
  end

  // per-cell operation
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      ops[i] = dlts_pkg::CELL_HOLD;
      if (do_tick && i == 0) ops[i] = dlts_pkg::CELL_TICK;
      if (do_shl) ops[i] = dlts_pkg::CELL_SHL;
      if (do_place) begin
        if (i == int'(pos_q)) ops[i] = dlts_pkg::CELL_LOAD;
        else if (i == int'(pos_q) + 1) ops[i] = dlts_pkg::CELL_SHR_ADJ;
        else if (i > int'(pos_q) + 1) ops[i] = dlts_pkg::CELL_SHR;
      end
    end
  end

  // chain of entry cells
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    dlts_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ops[g]),
      .ins_i   (ins),
      .left_i  (cells[(g == 0) ? 0 : g - 1]),
      .right_i (cells[(g == MAX_TASKS - 1) ? g : g + 1]),
      .entry_o (cells[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlts_pkg::ST_IDLE;
      count_q     <= '0;
      err_q       <= dlts_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    ran_q    <= ran_d;
    ran_id_q <= ran_id_d;
    tok_q    <= tok_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // list never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS))
    else $error("entry count beyond capacity");

  // walk pointer stays inside the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dlts_pkg::ST_WALK |-> {{(CW-PW){1'b0}}, pos_q} <= count_q)
    else $error("insert pointer past list end");

  // an accepted word always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != dlts_pkg::ST_IDLE)
    else $error("accepted word dropped");

endmodule
`default_nettype wire

[tb/tb_delta_list_task_scheduler.sv]
// Testbench: directed table plus random traffic checked against a delta list predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_delta_list_task_scheduler;

  localparam int unsigned Depth = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dlts_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dlts_pkg::out_t out_data_o;

  delta_list_task_scheduler #(.MAX_TASKS(Depth)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  q_id [Depth];
  logic [31:0] q_delta [Depth];
  logic [31:0] q_period [Depth];
  logic [7:0]  q_runs [Depth];
  int unsigned q_count;
  logic [1:0]  q_err;

  dlts_pkg::out_t expected_words[$];
  int errors = 0;
  bit sender_done = 1'b0;

  // Directed rows: stimulus with optional typed-in expectation
  typedef struct {
    dlts_pkg::in_t  word;
    bit             fixed;
    dlts_pkg::out_t want;
  } row_t;

  function automatic void sched_insert(logic [7:0] id, logic [31:0] dly,
                                       logic [31:0] per, logic [7:0] runs);
    longint unsigned prior_due;
    longint unsigned here_due;
    int unsigned pos;
    prior_due = 0;
    pos = 0;
    while (pos < q_count) begin
      here_due = prior_due + q_delta[pos];
      if (dly <= here_due) break;
      prior_due = here_due;
      pos++;
    end
    for (int i = q_count; i > pos; i--) begin
      q_id[i] = q_id[i-1];
      q_delta[i] = q_delta[i-1];
      q_period[i] = q_period[i-1];
      q_runs[i] = q_runs[i-1];
    end
    q_id[pos] = id;
    q_delta[pos] = 32'(dly - prior_due);
    q_period[pos] = per;
    q_runs[pos] = runs;
    if (pos < q_count) q_delta[pos+1] = q_delta[pos+1] - q_delta[pos];
    q_count++;
  endfunction

  function automatic dlts_pkg::out_t sched_predict(dlts_pkg::in_t w);
    dlts_pkg::out_t r;
    logic [7:0] hid;
    logic [31:0] hdly;
    logic [31:0] hper;
    logic [7:0] hruns;
    r = '0;
    case (dlts_pkg::kind_e'(w.kind))
      dlts_pkg::KIND_ADD: begin
        if (q_count >= Depth) q_err = dlts_pkg::ERR_FULL;
        else sched_insert(w.task_id, w.first_delay, w.repeat_period, 8'd0);
      end
      dlts_pkg::KIND_TICK: begin
        if (q_count == 0) begin
          q_err = dlts_pkg::ERR_EMPTY;
        end else if (q_delta[0] == 0) begin
          if (q_runs[0] != 8'hFF) q_runs[0]++;
          if (q_period[0] != 0) q_delta[0] = q_period[0];
        end else begin
          q_delta[0]--;
        end
      end
      dlts_pkg::KIND_DISPATCH: begin
        if (q_count > 0 && q_runs[0] != 0) begin
          hid = q_id[0];
          hdly = q_delta[0];
          hper = q_period[0];
          hruns = q_runs[0] - 8'd1;
          r.ran = 1'b1;
          r.ran_id = hid;
          for (int i = 0; i + 1 < q_count; i++) begin
            q_id[i] = q_id[i+1];
            q_delta[i] = q_delta[i+1];
            q_period[i] = q_period[i+1];
            q_runs[i] = q_runs[i+1];
          end
          q_count--;
          if (hper != 0) sched_insert(hid, hdly, hper, hruns);
        end
      end
      default: ;
    endcase
    r.entries = 4'(q_count);
    r.status = q_err;
    return r;
  endfunction

  function automatic dlts_pkg::in_t make_word(dlts_pkg::kind_e k, logic [7:0] id,
                                              logic [31:0] d, logic [31:0] p);
    dlts_pkg::in_t w;
    w.kind = k;
    w.task_id = id;
    w.first_delay = d;
    w.repeat_period = p;
    return w;
  endfunction

  function automatic dlts_pkg::out_t make_result(bit ran, logic [7:0] id, int unsigned n,
                                                 dlts_pkg::err_e s);
    dlts_pkg::out_t r;
    r.ran = ran;
    r.ran_id = id;
    r.entries = 4'(n);
    r.status = s;
    return r;
  endfunction

  // Send one word: hold valid until accepted; the caller drops valid
  task automatic send_word(dlts_pkg::in_t w, bit fixed, dlts_pkg::out_t want);
    dlts_pkg::out_t pred;
    in_data_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = sched_predict(w);
    if (fixed && pred != want) begin
      $error("directed row disagrees with predictor: %h vs %h", want, pred);
      errors++;
    end
    expected_words.push_back(fixed ? want : pred);
    @(negedge clk_i);
  endtask

  // Pick a delay that is mostly small so ticks reach the head
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  // Random word weighted toward ticks and dispatches
  function automatic dlts_pkg::in_t rand_word();
    int unsigned sel;
    logic [31:0] per;
    sel = $urandom_range(0, 99);
    per = ($urandom_range(0, 2) == 0) ? 32'd0 : pick_delay();
    if (sel < 22)
      return make_word(dlts_pkg::KIND_ADD, 8'($urandom()), pick_delay(), per);
    if (sel < 62)
      return make_word(dlts_pkg::KIND_TICK, 8'($urandom()), $urandom(), $urandom());
    if (sel < 97)
      return make_word(dlts_pkg::KIND_DISPATCH, 8'($urandom()), $urandom(), $urandom());
    return make_word(dlts_pkg::KIND_NONE, 8'($urandom()), $urandom(), $urandom());
  endfunction

  // Stimulus
  initial begin
    row_t rows[$];
    row_t r;
    int unsigned gap;
    for (int i = 0; i < Depth; i++) begin
      q_id[i] = '0; q_delta[i] = '0; q_period[i] = '0; q_runs[i] = '0;
    end
    q_count = 0;
    q_err = dlts_pkg::ERR_NONE;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list cases, then fill to the limit with extreme values among the adds, then ticks and dispatches
    rows.push_back('{make_word(dlts_pkg::KIND_DISPATCH, 8'hAA, 32'd0, 32'd0), 1'b1,
                     make_result(1'b0, 8'd0, 0, dlts_pkg::ERR_NONE)});
    rows.push_back('{make_word(dlts_pkg::KIND_NONE, 8'hFF, '1, '1), 1'b1,
                     make_result(1'b0, 8'd0, 0, dlts_pkg::ERR_NONE)});
    rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b1,
                     make_result(1'b0, 8'd0, 0, dlts_pkg::ERR_EMPTY)});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h00, 32'd0, 32'd0), 1'b1,
                     make_result(1'b0, 8'd0, 1, dlts_pkg::ERR_EMPTY)});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                     1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h11, 32'd3, 32'd2), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h22, 32'd3, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h33, 32'd0, 32'd1), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h44, 32'd5, 32'd4), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h55, 32'h8000_0000, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h66, 32'd1, 32'd7), 1'b1,
                     make_result(1'b0, 8'd0, 8, dlts_pkg::ERR_EMPTY)});
    rows.push_back('{make_word(dlts_pkg::KIND_ADD, 8'h77, 32'd1, 32'd1), 1'b1,
                     make_result(1'b0, 8'd0, 8, dlts_pkg::ERR_FULL)});
    rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_DISPATCH, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_DISPATCH, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_DISPATCH, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    rows.push_back('{make_word(dlts_pkg::KIND_DISPATCH, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    for (int i = 0; i < 6; i++)
      rows.push_back('{make_word(dlts_pkg::KIND_TICK, 8'h00, 32'd0, 32'd0), 1'b0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      send_word(r.word, r.fixed, r.want);
    end
    in_valid_i <= 1'b0;

    // Hold until every result has drained
    while (expected_words.size() != 0) @(negedge clk_i);

    // Random traffic in bursts
    for (int n = 0; n < 1150; ) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      for (int b = $urandom_range(1, 16); b > 0 && n < 1150; b--, n++)
        send_word(rand_word(), 1'b0, '0);
      if (n > 500 && n < 520) begin
        in_valid_i <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver stall pattern: long ready runs mixed with stalls
  initial begin
    int unsigned phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if ((phase / 200) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) < 60);
    end
  end

  // Output check
  always @(posedge clk_i) begin
    dlts_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: %h", out_data_o);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.ran !== want.ran) begin
          $error("ran: expected %0d actual %0d", want.ran, out_data_o.ran);
          errors++;
        end
        if (out_data_o.ran_id !== want.ran_id) begin
          $error("ran_id: expected %0d actual %0d", want.ran_id, out_data_o.ran_id);
          errors++;
        end
        if (out_data_o.entries !== want.entries) begin
          $error("entries: expected %0d actual %0d", want.entries, out_data_o.entries);
          errors++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  // Finish once drained
  initial begin
    wait (sender_done);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/dlts_pkg.sv
sv/dlts_cell.sv
sv/delta_list_task_scheduler.sv
tb/tb_delta_list_task_scheduler.sv
